// File: rtl/hough_line_peak_finder_unit_defines.svh
// Assertion macros for the Hough line peak finder.
// Both sample on clk and are switched off while rst is high.
`ifndef HOUGH_LINE_PEAK_FINDER_UNIT_DEFINES_SVH
`define HOUGH_LINE_PEAK_FINDER_UNIT_DEFINES_SVH

// cond must hold at every clock edge
`define HLPF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define HLPF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/hlpf_pkg.sv
`default_nettype none

package hlpf_pkg;

  // Frame and accumulator geometry
  localparam int MAX_WIDTH      = 512;
  localparam int MAX_HEIGHT     = 512;
  localparam int THETA_STEPS    = 180;
  localparam int MAX_LINES      = 64;
  localparam int VOTE_BITS      = 12;
  localparam int TRIG_FRAC_BITS = 16;
  localparam int EDGE_LEVEL     = 128;
  localparam int ROW_LIMIT      = 2047;

  localparam int COORD_W = 9;
  localparam int SIZE_W  = 10;
  localparam int ROW_W   = 11;
  localparam int THETA_W = 8;
  localparam int RHO_W   = 11;
  localparam int CNT_W   = $clog2(MAX_LINES + 1);
  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;

  localparam int ACC_DEPTH = ROW_LIMIT * THETA_STEPS;
  localparam int ACC_AW    = $clog2(ACC_DEPTH + THETA_STEPS + 2);

  localparam logic [THETA_W-1:0]   THETA_LAST = THETA_W'(THETA_STEPS - 1);
  localparam logic [VOTE_BITS-1:0] VOTE_MAX   = {VOTE_BITS{1'b1}};

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAGONAL  = 3'd3;

  // One line of the peak list
  typedef struct packed {
    logic signed [RHO_W-1:0] rho;
    logic [THETA_W-1:0]      theta;
    logic [VOTE_BITS-1:0]    votes;
  } entry_t;

  // Insertion into the peak list
  typedef struct packed {
    logic   valid;
    entry_t ent;
  } ins_t;

  // Accumulator access from one client
  typedef struct packed {
    logic                 rd_en;
    logic [ACC_AW-1:0]    rd_addr;
    logic                 wr_en;
    logic [ACC_AW-1:0]    wr_addr;
    logic [VOTE_BITS-1:0] wr_data;
  } mem_req_t;

  // Sine table, quarter wave, built at elaboration in Q60 then rounded
  localparam int QUARTER = 90;
  localparam int HALF    = 180;
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_STEP = PI_Q60 / 180;
  localparam logic [63:0] PI_REM  = PI_Q60 % 180;
  localparam logic [63:0] SERIES_DIV [16] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
    64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056
  };

  typedef logic [QUARTER:0][TRIG_FRAC_BITS:0] sin_tab_t;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [TRIG_FRAC_BITS:0] sine_entry(input int deg);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = PI_STEP * 64'(deg) + (PI_REM * 64'(deg)) / 64'd180;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 16; k++) begin
      if (term != 64'd0) begin
        term = mul_q60(term, x2) / SERIES_DIV[k-1];
        if ((k & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    sum = sum + (64'd1 << (59 - TRIG_FRAC_BITS));
    return (TRIG_FRAC_BITS+1)'(sum >> (60 - TRIG_FRAC_BITS));
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int d = 0; d <= QUARTER; d++) tab[d] = sine_entry(d);
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // sin of theta degrees, theta in 0..179
  function automatic logic signed [TRIG_W-1:0] trig_sin(input logic [THETA_W-1:0] t);
    logic [6:0] idx;
    idx = (t <= THETA_W'(QUARTER)) ? t[6:0] : 7'(THETA_W'(HALF) - t);
    return $signed({1'b0, SIN_TAB[idx]});
  endfunction

  // cos of theta degrees, theta in 0..179
  function automatic logic signed [TRIG_W-1:0] trig_cos(input logic [THETA_W-1:0] t);
    logic [6:0]              idx;
    logic signed [TRIG_W-1:0] mag;
    idx = (t <= THETA_W'(QUARTER)) ? 7'(THETA_W'(QUARTER) - t) : 7'(t - THETA_W'(QUARTER));
    mag = $signed({1'b0, SIN_TAB[idx]});
    return (t <= THETA_W'(QUARTER)) ? mag : -mag;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hough_line_peak_finder_unit.sv
`default_nettype none
// Hough line peak finder. Pixels of a gray frame arrive one word at a time in
// raster order; a pixel above 128 votes in all 180 angles, one accumulator
// read-modify-write per cycle through one read and one write port of the
// accumulator RAM, so an edge pixel holds off the next pixel until it has
// issued its last angle, and any other pixel is taken once the angles before
// it are issued. After the last pixel the vote pipeline drains, and then the
// whole accumulator (2047 x 180 cells) is swept once, one cell per cycle, to
// find and sort peaks while zeroing the cells. The same sweep runs once after
// reset as a clearing pass, during which no pixel is taken (configuration
// writes are). Results then leave one word per cycle while out_stall is low,
// strongest first; a frame with no line gives a single word with line_valid
// low and last_line high.

`include "hough_line_peak_finder_unit_defines.svh"

module hough_line_peak_finder_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [hlpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hlpf_pkg::VOTE_BITS-1:0]   cfg_data,
  // pixels
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       pixel_value,
  // lines
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [hlpf_pkg::RHO_W-1:0]     line_rho,
  output logic [hlpf_pkg::THETA_W-1:0]          theta_index,
  output logic [hlpf_pkg::VOTE_BITS-1:0]        vote_count,
  output logic                                  line_valid,
  output logic                                  last_line,
  output logic                                  list_overflow
);
  import hlpf_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT, ST_CLEAR, ST_VOTE, ST_DRAIN, ST_SCAN, ST_EMIT
  } state_t;

  state_t               state;
  logic [VOTE_BITS-1:0] thr;
  logic [SIZE_W-1:0]    img_w, img_h, diag;
  logic [COORD_W-1:0]   col, row;

  logic [SIZE_W-1:0]    w_eff, h_eff;
  logic                 col_wrap, row_wrap;
  logic                 in_acc, slot_free;

  logic                 vote_start, vote_rdy, vote_idle;
  logic                 scan_start, scan_find, scan_busy;
  mem_req_t             vreq, sreq, req;
  ins_t                 peak;
  entry_t               head;
  logic [CNT_W-1:0]     cnt;
  logic                 overflow, pop, clr_ovf;

  logic [VOTE_BITS-1:0] acc_mem [ACC_DEPTH];
  logic [VOTE_BITS-1:0] rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr   <= 12'd50;
      img_w <= 10'd512;
      img_h <= 10'd512;
      diag  <= 10'd724;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr   <= cfg_data;
        CFG_WIDTH:     img_w <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT:    img_h <= cfg_data[SIZE_W-1:0];
        CFG_DIAGONAL:  diag  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size, zero taken as one, clipped to the maximum
  always_comb begin
    w_eff = (img_w == '0) ? SIZE_W'(1) :
            (img_w > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : img_w;
    h_eff = (img_h == '0) ? SIZE_W'(1) :
            (img_h > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : img_h;
    col_wrap = ({1'b0, col} + 1'b1) >= w_eff;
    row_wrap = ({1'b0, row} + 1'b1) >= h_eff;
  end

  // handshakes and unit control
  assign in_stall   = !((state == ST_VOTE) && vote_rdy);
  assign in_acc     = in_valid && !in_stall;
  assign vote_start = in_acc && (pixel_value > 8'(EDGE_LEVEL));
  assign scan_start = (state == ST_INIT) || ((state == ST_DRAIN) && vote_idle);
  assign scan_find  = state == ST_DRAIN;
  assign slot_free  = !out_valid || !out_stall;
  assign pop        = (state == ST_EMIT) && slot_free && (cnt != '0);
  assign clr_ovf    = (state == ST_EMIT) && slot_free && (cnt <= CNT_W'(1));

  hlpf_vote u_vote (
    .clk     (clk),
    .rst     (rst),
    .start   (vote_start),
    .x       (col),
    .y       (row),
    .diag    (diag),
    .rd_data (rd_data),
    .req     (vreq),
    .ready   (vote_rdy),
    .idle    (vote_idle)
  );

  hlpf_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .find_en (scan_find),
    .thr     (thr),
    .diag    (diag),
    .rd_data (rd_data),
    .req     (sreq),
    .peak    (peak),
    .busy    (scan_busy)
  );

  hlpf_list u_list (
    .clk      (clk),
    .rst      (rst),
    .ins      (peak),
    .pop      (pop),
    .clr_ovf  (clr_ovf),
    .head     (head),
    .cnt      (cnt),
    .overflow (overflow)
  );

  // accumulator RAM, voting and sweeping never overlap
  assign req = ((state == ST_VOTE) || (state == ST_DRAIN)) ? vreq : sreq;

  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data <= acc_mem[req.rd_addr[ACC_AW-1:0]];
    if (req.wr_en) acc_mem[req.wr_addr] <= req.wr_data;
  end

  // main sequencer, pixel counters and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_INIT:  state <= ST_CLEAR;
        ST_CLEAR: if (!scan_busy) state <= ST_VOTE;
        ST_VOTE: begin
          if (in_acc) begin
            if (col_wrap) begin
              col <= '0;
              if (row_wrap) begin
                row   <= '0;
                state <= ST_DRAIN;
              end else begin
                row <= row + 1'b1;
              end
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        ST_DRAIN: if (vote_idle) state <= ST_SCAN;
        ST_SCAN:  if (!scan_busy) state <= ST_EMIT;
        ST_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (cnt != '0) begin
              line_rho      <= head.rho;
              theta_index   <= head.theta;
              vote_count    <= head.votes;
              line_valid    <= 1'b1;
              last_line     <= cnt == CNT_W'(1);
              list_overflow <= overflow;
              if (cnt == CNT_W'(1)) state <= ST_VOTE;
            end else begin
              line_rho      <= '0;
              theta_index   <= '0;
              vote_count    <= '0;
              line_valid    <= 1'b0;
              last_line     <= 1'b1;
              list_overflow <= 1'b0;
              state         <= ST_VOTE;
            end
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  `HLPF_ASSERT_IMPLY(a_empty_is_last, out_valid && !line_valid, last_line, "empty word not last")
  `HLPF_ASSERT_IMPLY(a_no_vote_in_sweep, state == ST_SCAN, !vreq.rd_en && !vreq.wr_en, "vote during sweep")
  `HLPF_ASSERT_ALWAYS(a_list_bound, cnt <= CNT_W'(MAX_LINES), "peak list count beyond bound")

endmodule

`default_nettype wire

// File: rtl/hlpf_vote.sv
`default_nettype none

// Vote pipeline: one theta per cycle, ROM, products, rho, row, address,
// then read-modify-write of the accumulator cell.
module hlpf_vote (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [hlpf_pkg::COORD_W-1:0]  x,
  input  wire logic [hlpf_pkg::COORD_W-1:0]  y,
  input  wire logic [hlpf_pkg::SIZE_W-1:0]   diag,
  input  wire logic [hlpf_pkg::VOTE_BITS-1:0] rd_data,
  output hlpf_pkg::mem_req_t                 req,
  output logic                               ready,
  output logic                               idle
);
  import hlpf_pkg::*;

  logic                      run;
  logic [THETA_W-1:0]        tc;
  logic [COORD_W-1:0]        xs, ys;

  logic                      v1;
  logic [THETA_W-1:0]        t1;
  logic [COORD_W-1:0]        x1, y1;
  logic signed [TRIG_W-1:0]  c1, s1;

  logic                      v2;
  logic [THETA_W-1:0]        t2;
  logic signed [27:0]        px, py;

  logic                      v3;
  logic [THETA_W-1:0]        t3;
  logic signed [12:0]        rho3;

  logic                      v4;
  logic [THETA_W-1:0]        t4;
  logic [ROW_W-1:0]          r4;

  logic                      v5, v6;
  logic [ACC_AW-1:0]         addr5, addr6;

  logic signed [28:0]        sum;
  logic signed [28:0]        adj;
  logic signed [13:0]        rr;
  logic                      in_range;

  assign ready = !run || (tc == THETA_LAST);
  assign idle  = !run && !v1 && !v2 && !v3 && !v4 && !v5 && !v6;

  // rho truncated toward zero, then offset by the diagonal
  always_comb begin
    sum      = {px[27], px} + {py[27], py};
    adj      = sum + (sum[28] ? 29'sh0FFFF : 29'sh0);
    rr       = $signed({rho3[12], rho3}) + $signed({4'b0, diag});
    in_range = !rr[13] && (rr[12:0] <= {2'b0, diag, 1'b0});
  end

  // theta sequencer and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      tc  <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
    end else begin
      if (start) begin
        run <= 1'b1;
        tc  <= '0;
      end else if (run) begin
        if (tc == THETA_LAST) run <= 1'b0;
        tc <= tc + 1'b1;
      end
      v1 <= run;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && in_range;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      xs <= x;
      ys <= y;
    end
    t1    <= tc;
    x1    <= xs;
    y1    <= ys;
    c1    <= trig_cos(tc);
    s1    <= trig_sin(tc);
    t2    <= t1;
    px    <= $signed({1'b0, x1}) * c1;
    py    <= $signed({1'b0, y1}) * s1;
    t3    <= t2;
    rho3  <= adj[28:16];
    t4    <= t3;
    r4    <= rr[ROW_W-1:0];
    addr5 <= ACC_AW'(ACC_AW'(r4) * ACC_AW'(THETA_STEPS)) + ACC_AW'(t4);
    addr6 <= addr5;
  end

  // read at stage five, saturating write back in the cycle after
  always_comb begin
    req.rd_en   = v5;
    req.rd_addr = addr5;
    req.wr_en   = v6;
    req.wr_addr = addr6;
    req.wr_data = (rd_data == VOTE_MAX) ? rd_data : rd_data + 1'b1;
  end

endmodule

`default_nettype wire

// File: rtl/hlpf_scan.sv
`default_nettype none

// Accumulator sweep: reads every cell in raster order, zeroes it behind the
// read, and runs the 3x3 peak test on a two-row shift line.
module hlpf_scan (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           find_en,
  input  wire logic [hlpf_pkg::VOTE_BITS-1:0] thr,
  input  wire logic [hlpf_pkg::SIZE_W-1:0]    diag,
  input  wire logic [hlpf_pkg::VOTE_BITS-1:0] rd_data,
  output hlpf_pkg::mem_req_t                  req,
  output hlpf_pkg::ins_t                      peak,
  output logic                                busy
);
  import hlpf_pkg::*;

  localparam int LINE_TAPS  = 2 * THETA_STEPS + 3;
  localparam int CENTER_TAP = THETA_STEPS + 1;
  localparam int TAP_UL     = 2 * THETA_STEPS + 2;
  localparam int TAP_U      = 2 * THETA_STEPS + 1;
  localparam int TAP_UR     = 2 * THETA_STEPS;
  localparam int TAP_L      = THETA_STEPS + 2;
  localparam int TAP_R      = THETA_STEPS;
  localparam logic [ACC_AW-1:0] SWEEP_LAST = ACC_AW'(ACC_DEPTH + CENTER_TAP - 1);

  logic                  run, fen;
  logic [ACC_AW-1:0]     a, a1;
  logic                  p1, p1_mem;
  logic                  ev;
  logic [ROW_W-1:0]      cr;
  logic [THETA_W-1:0]    ct;
  logic [VOTE_BITS-1:0]  sl [LINE_TAPS];

  logic                  a_mem;
  logic [VOTE_BITS-1:0]  vc;
  logic                  up, dn, lf, rt, in_rows, beaten, is_peak;

  assign a_mem = a < ACC_AW'(ACC_DEPTH);
  assign busy  = run || p1 || ev || peak.valid;

  always_comb begin
    req.rd_en   = run && a_mem;
    req.rd_addr = a;
    req.wr_en   = p1_mem;
    req.wr_addr = a1;
    req.wr_data = '0;
  end

  // sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      run        <= 1'b0;
      p1         <= 1'b0;
      p1_mem     <= 1'b0;
      ev         <= 1'b0;
      peak.valid <= 1'b0;
    end else begin
      if (start) begin
        run <= 1'b1;
        a   <= '0;
        fen <= find_en;
      end else if (run) begin
        if (a == SWEEP_LAST) run <= 1'b0;
        a <= a + 1'b1;
      end
      p1         <= run;
      p1_mem     <= run && a_mem;
      ev         <= p1 && (a1 >= ACC_AW'(CENTER_TAP));
      peak.valid <= ev && fen && is_peak;
    end
  end

  // shift line and centre position
  always_ff @(posedge clk) begin
    a1 <= a;
    if (p1) begin
      sl[0] <= p1_mem ? rd_data : '0;
      for (int i = 1; i < LINE_TAPS; i++) sl[i] <= sl[i-1];
    end
    if (start) begin
      cr <= '0;
      ct <= '0;
    end else if (ev) begin
      if (ct == THETA_LAST) begin
        ct <= '0;
        cr <= cr + 1'b1;
      end else begin
        ct <= ct + 1'b1;
      end
    end
    peak.ent.rho   <= RHO_W'($signed({1'b0, cr}) - $signed({2'b0, diag}));
    peak.ent.theta <= ct;
    peak.ent.votes <= vc;
  end

  // 3x3 test, neighbours outside the used rows or angles skipped
  always_comb begin
    vc      = sl[CENTER_TAP];
    up      = cr != '0;
    dn      = cr < {diag, 1'b0};
    lf      = ct != '0;
    rt      = ct != THETA_LAST;
    in_rows = cr <= {diag, 1'b0};
    beaten  = (up && lf && sl[TAP_UL] > vc) || (up && sl[TAP_U] > vc) ||
              (up && rt && sl[TAP_UR] > vc) || (lf && sl[TAP_L] > vc) ||
              (rt && sl[TAP_R] > vc) || (dn && lf && sl[2] > vc) ||
              (dn && sl[1] > vc) || (dn && rt && sl[0] > vc);
    is_peak = in_rows && (vc > thr) && !beaten;
  end

endmodule

`default_nettype wire

// File: rtl/hlpf_cell.sv
`default_nettype none

// One place of the sorted peak list. Keeps its word, takes the new word,
// takes its left neighbour's word on insert, or its right one's on pop.
module hlpf_cell (
  input  wire logic            clk,
  input  wire hlpf_pkg::ins_t  ins,
  input  wire logic            pop,
  input  wire logic            occ,
  input  wire logic            left_keep,
  input  wire hlpf_pkg::entry_t left_ent,
  input  wire hlpf_pkg::entry_t right_ent,
  output hlpf_pkg::entry_t     ent,
  output logic                 keep
);
  import hlpf_pkg::*;

  // equal votes stay ahead: ties keep scan order
  assign keep = occ && (ent.votes >= ins.ent.votes);

  always_ff @(posedge clk) begin
    if (ins.valid && !keep) begin
      ent <= left_keep ? ins.ent : left_ent;
    end else if (pop) begin
      ent <= right_ent;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hlpf_list.sv
`default_nettype none

// Peak list as a chain of cells, strongest at cell 0.
module hlpf_list (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire hlpf_pkg::ins_t              ins,
  input  wire logic                        pop,
  input  wire logic                        clr_ovf,
  output hlpf_pkg::entry_t                 head,
  output logic [hlpf_pkg::CNT_W-1:0]       cnt,
  output logic                             overflow
);
  import hlpf_pkg::*;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LINES);

  entry_t ent  [MAX_LINES];
  logic   keep [MAX_LINES];

  assign head = ent[0];

  for (genvar i = 0; i < MAX_LINES; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic   lk;
    entry_t le, re;
    assign lk = (i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i-1];
    assign le = (i == 0) ? ins.ent : ent[(i == 0) ? 0 : i-1];
    assign re = (i == MAX_LINES-1) ? ent[i] : ent[(i == MAX_LINES-1) ? i : i+1];

    hlpf_cell u_cell (
      .clk       (clk),
      .ins       (ins),
      .pop       (pop),
      .occ       (IDX < cnt),
      .left_keep (lk),
      .left_ent  (le),
      .right_ent (re),
      .ent       (ent[i]),
      .keep      (keep[i])
    );
  end

  // fill count and overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      overflow <= 1'b0;
    end else begin
      if (ins.valid) begin
        if (cnt == FULL) overflow <= 1'b1;
        else cnt <= cnt + 1'b1;
      end else if (pop) begin
        cnt <= cnt - 1'b1;
      end
      if (clr_ovf) overflow <= 1'b0;
    end
  end

endmodule

`default_nettype wire
